>>> sv/stack_queue_heap_trace_checker_assert.svh
// Assertion macros for the trace checker.
`ifndef STACK_QUEUE_HEAP_TRACE_CHECKER_ASSERT_SVH
`define STACK_QUEUE_HEAP_TRACE_CHECKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SQH_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define SQH_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`else
`define SQH_ASSERT_IMP(lbl, clk, rst, a, c)
`define SQH_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

>>> sv/sqh_pkg.sv
// ----------------------------------------------------------------------------
// sqh_pkg
// Shared types and codes of the trace checker.
// ----------------------------------------------------------------------------
`default_nettype none
package sqh_pkg;
  localparam logic [2:0] VERDICT_IMPOSSIBLE = 3'd0;
  localparam logic [2:0] VERDICT_NOT_SURE   = 3'd1;
  localparam logic [2:0] VERDICT_STACK      = 3'd2;
  localparam logic [2:0] VERDICT_PRIORITY   = 3'd3;
  localparam logic [2:0] VERDICT_QUEUE      = 3'd4;
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LINEAR, ST_HPUSH_RD, ST_HPUSH_CMP, ST_HPOP_LAST, ST_HPOP_RDL,
    ST_HPOP_RDR, ST_HPOP_CMP, ST_HPOP_WR, ST_DONE
  } sqh_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the item
    logic linear;      // apply stack and queue, heap checks, flags
    logic hpush_init;  // place new element position
    logic hpush_rd;    // read parent
    logic hpush_step;  // compare parent, move or finish
    logic hpop_last;   // read last element
    logic hpop_rdl;    // read left child
    logic hpop_rdr;    // read right child
    logic hpop_step;   // compare children, move or finish
    logic hwrite_hole; // write pending value into hole
    logic emit;        // copy the flags into the result register
  } sqh_cmd_t;

  typedef struct packed {
    logic heap_push;   // a heap insertion is needed
    logic heap_pop;    // a heap removal with non-empty remainder is needed
    logic up_done;     // sift up finished
    logic down_done;   // sift down finished
  } sqh_status_t;
endpackage
`default_nettype wire

>>> sv/sqh_ctrl.sv
// ----------------------------------------------------------------------------
// sqh_ctrl
// Sequencer for one trace item, steering the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stack_queue_heap_trace_checker_assert.svh"
module sqh_ctrl
  import sqh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output sqh_cmd_t         cmd,
  input  wire sqh_status_t status
);
  sqh_state_t state, state_next;
  logic       busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign busy = (state != ST_IDLE);
  // A new item may enter while a result waits, but its result must not land
  // on an untaken one; the DONE state waits for the result slot.
  assign in_ready = !busy;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_LINEAR;
        end
      end
      ST_LINEAR: begin
        cmd.linear = 1'b1;
        if (status.heap_push) begin
          cmd.hpush_init = 1'b1;
          state_next = ST_HPUSH_RD;
        end else if (status.heap_pop) begin
          state_next = ST_HPOP_LAST;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_HPUSH_RD: begin
        if (status.up_done) begin
          cmd.hwrite_hole = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.hpush_rd = 1'b1;
          state_next = ST_HPUSH_CMP;
        end
      end
      ST_HPUSH_CMP: begin
        cmd.hpush_step = 1'b1;
        state_next = ST_HPUSH_RD;
      end
      ST_HPOP_LAST: begin
        cmd.hpop_last = 1'b1;
        state_next = ST_HPOP_RDL;
      end
      ST_HPOP_RDL: begin
        if (status.down_done) begin
          cmd.hwrite_hole = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.hpop_rdl = 1'b1;
          state_next = ST_HPOP_RDR;
        end
      end
      ST_HPOP_RDR: begin
        cmd.hpop_rdr = 1'b1;
        state_next = ST_HPOP_CMP;
      end
      ST_HPOP_CMP: begin
        cmd.hpop_step = 1'b1;
        state_next = ST_HPOP_RDL;
      end
      ST_HPOP_WR: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `SQH_ASSERT_IMP(a_no_accept_busy, clk, rst, busy, !in_ready)
  `SQH_ASSERT_NXT(a_load_linear, clk, rst, cmd.load, state == ST_LINEAR)
  `SQH_ASSERT_NXT(a_done_valid, clk, rst, state == ST_DONE && state_next == ST_IDLE, out_valid)
endmodule
`default_nettype wire

>>> sv/sqh_datapath.sv
// ----------------------------------------------------------------------------
// sqh_datapath
// Stores, pointers, flags and the heap sift unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stack_queue_heap_trace_checker_assert.svh"
module sqh_datapath
  import sqh_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start_new,
  input  wire logic        req_type,
  input  wire logic [15:0] value,
  input  wire sqh_cmd_t    cmd,
  output sqh_status_t      status,
  output logic             stack_ok,
  output logic             queue_ok,
  output logic             heap_ok,
  output logic [2:0]       verdict,
  output logic             overflow
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [VALUE_WIDTH-1:0] lifo_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] fifo_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] heap_mem [DEPTH];

  logic [CW-1:0] lifo_count, fifo_count, heap_count;
  logic [AW-1:0] fifo_head, fifo_tail;
  logic [2:0]    alive;
  logic          overflow_seen;
  logic          op;
  logic [VALUE_WIDTH-1:0] v;

  logic [VALUE_WIDTH-1:0] lifo_top, fifo_front, heap_top;
  logic [VALUE_WIDTH-1:0] rd_a, rd_b;
  logic [CW-1:0] pos;
  logic [KW-1:0] kid;
  logic [VALUE_WIDTH-1:0] hold;   // value that ends in the hole
  logic          heap_push_r, heap_pop_r;

  // Item capture; start clears the small state at once.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req_type;
      v  <= VALUE_WIDTH'(value);
    end
  end

  // Top-of-structure reads, registered: taken during the load cycle with
  // post-start counts so they are ready for the linear step.
  logic [CW-1:0] lc_eff;
  logic [AW-1:0] fh_eff;
  assign lc_eff = start_new ? '0 : lifo_count;
  assign fh_eff = start_new ? '0 : fifo_head;

  logic [CW-1:0] lc_dec;
  assign lc_dec = lc_eff - CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lifo_top   <= lifo_mem[lc_dec[AW-1:0]];
      fifo_front <= fifo_mem[fh_eff];
      heap_top   <= heap_mem[0];
    end
  end

  logic [2:0] alive_n;
  logic ovf_n;
  logic h_push, h_pop;
  always_comb begin
    alive_n = alive;
    ovf_n = overflow_seen;
    h_push = 1'b0;
    h_pop = 1'b0;
    if (op == REQ_PUSH) begin
      if (alive[0] && lifo_count >= DEPTH_C) ovf_n = 1'b1;
      if (alive[1] && fifo_count >= DEPTH_C) ovf_n = 1'b1;
      if (alive[2]) begin
        if (heap_count >= DEPTH_C) ovf_n = 1'b1;
        else h_push = 1'b1;
      end
    end else begin
      if (alive[0] && (lifo_count == '0 || lifo_top != v)) alive_n[0] = 1'b0;
      if (alive[1] && (fifo_count == '0 || fifo_front != v)) alive_n[1] = 1'b0;
      if (alive[2]) begin
        if (heap_count == '0 || heap_top != v) alive_n[2] = 1'b0;
        else h_pop = (heap_count != CW'(1));
      end
    end
  end

  assign status.heap_push = h_push;
  assign status.heap_pop  = h_pop;
  assign status.up_done   = (pos == '0) || heap_push_r;
  assign status.down_done = heap_pop_r;

  // Child indices run one bit wider than the count so they never wrap.
  logic [KW-1:0] hc_x;
  assign hc_x = {1'b0, heap_count};
  logic [CW-1:0] parent;
  assign parent = (pos - CW'(1)) >> 1;
  logic [KW-1:0] lkid, rkid;
  assign lkid = {pos, 1'b0} + KW'(1);
  assign rkid = lkid + KW'(1);

  // Compare stage: left in rd_a after hpop_rdr, right arrives in rd_b.
  logic [VALUE_WIDTH-1:0] best;
  logic [KW-1:0] best_idx;
  always_comb begin
    best = rd_a; best_idx = kid;
    if (kid + KW'(1) < hc_x && rd_b > rd_a) begin
      best = rd_b; best_idx = kid + KW'(1);
    end
  end

  logic push_move, pop_move;
  assign push_move = (rd_b < hold);
  assign pop_move  = (kid < hc_x) && (best > hold);

  // heap_push_r / heap_pop_r mark that the sift found its place.
  always_ff @(posedge clk) begin
    if (rst) begin
      lifo_count <= '0; fifo_count <= '0; heap_count <= '0;
      fifo_head <= '0; fifo_tail <= '0;
      alive <= 3'b111; overflow_seen <= 1'b0;
      heap_push_r <= 1'b0; heap_pop_r <= 1'b0;
    end else begin
      if (cmd.load && start_new) begin
        lifo_count <= '0; fifo_count <= '0; heap_count <= '0;
        fifo_head <= '0; fifo_tail <= '0;
        alive <= 3'b111; overflow_seen <= 1'b0;
      end
      if (cmd.load) begin
        heap_push_r <= 1'b0; heap_pop_r <= 1'b0;
      end
      if (cmd.linear) begin
        alive <= alive_n;
        overflow_seen <= ovf_n;
        if (op == REQ_PUSH) begin
          if (alive[0] && lifo_count < DEPTH_C) lifo_count <= lifo_count + CW'(1);
          if (alive[1] && fifo_count < DEPTH_C) begin
            fifo_tail <= (fifo_tail == AW'(DEPTH - 1)) ? '0 : fifo_tail + AW'(1);
            fifo_count <= fifo_count + CW'(1);
          end
          if (h_push) heap_count <= heap_count + CW'(1);
        end else begin
          if (alive_n[0]) lifo_count <= lifo_count - CW'(1);
          if (alive_n[1]) begin
            fifo_head <= (fifo_head == AW'(DEPTH - 1)) ? '0 : fifo_head + AW'(1);
            fifo_count <= fifo_count - CW'(1);
          end
          if (alive_n[2]) heap_count <= heap_count - CW'(1);
        end
      end
      if (cmd.hpush_step && !push_move) heap_push_r <= 1'b1;
      if (cmd.hpop_step && !pop_move) heap_pop_r <= 1'b1;
    end
  end

  // Stack and queue writes on push.
  always_ff @(posedge clk) begin
    if (cmd.linear && op == REQ_PUSH) begin
      if (alive[0] && lifo_count < DEPTH_C) lifo_mem[lifo_count[AW-1:0]] <= v;
      if (alive[1] && fifo_count < DEPTH_C) fifo_mem[fifo_tail] <= v;
    end
  end

  // Heap sift unit: one read or one write of heap_mem per cycle.
  logic heap_we;
  logic [AW-1:0] heap_wa;
  logic [VALUE_WIDTH-1:0] heap_wd;
  logic heap_re;
  logic [AW-1:0] heap_ra;

  always_comb begin
    heap_we = 1'b0; heap_wa = pos[AW-1:0]; heap_wd = hold;
    heap_re = 1'b0; heap_ra = parent[AW-1:0];
    if (cmd.hwrite_hole) heap_we = 1'b1;
    if (cmd.hpush_step && push_move) begin
      heap_we = 1'b1; heap_wd = rd_b;
    end
    if (cmd.hpop_step && pop_move) begin
      heap_we = 1'b1; heap_wd = best;
    end
    if (cmd.hpush_rd) begin heap_re = 1'b1; heap_ra = parent[AW-1:0]; end
    if (cmd.hpop_last) begin heap_re = 1'b1; heap_ra = heap_count[AW-1:0]; end
    if (cmd.hpop_rdl) begin heap_re = 1'b1; heap_ra = lkid[AW-1:0]; end
    if (cmd.hpop_rdr) begin heap_re = 1'b1; heap_ra = rkid[AW-1:0]; end
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (heap_re) rd_b <= heap_mem[heap_ra];
  end

  // The read of the last element lands in rd_b in the cycle after hpop_last, so
  // hold is taken from rd_b on the first left-read cycle.
  logic hold_pend;
  always_ff @(posedge clk) begin
    if (rst) hold_pend <= 1'b0;
    else hold_pend <= cmd.hpop_last;
  end

  // On a push rd_b holds the parent; on a pop rd_a holds the left child.
  always_ff @(posedge clk) begin
    if (cmd.hpush_init) begin
      pos <= heap_count;
      hold <= v;
    end else if (hold_pend) begin
      hold <= rd_b;
    end
    if (cmd.linear && h_pop) pos <= '0;
    if (cmd.hpush_rd) kid <= {1'b0, parent};
    if (cmd.hpop_rdl) kid <= lkid;
    if (cmd.hpop_rdr) rd_a <= rd_b;
    if (cmd.hpop_step && pop_move) pos <= best_idx[CW-1:0];
    if (cmd.hpush_step && push_move) pos <= kid[CW-1:0];
  end

  // Result register, loaded once the item is finished.
  logic [2:0] verdict_n;
  always_comb begin
    unique case (alive)
      3'b000: verdict_n = VERDICT_IMPOSSIBLE;
      3'b001: verdict_n = VERDICT_STACK;
      3'b010: verdict_n = VERDICT_QUEUE;
      3'b100: verdict_n = VERDICT_PRIORITY;
      default: verdict_n = VERDICT_NOT_SURE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      stack_ok <= alive[0];
      queue_ok <= alive[1];
      heap_ok  <= alive[2];
      verdict  <= verdict_n;
      overflow <= overflow_seen;
    end
  end

  `SQH_ASSERT_IMP(a_lifo_bound, clk, rst, 1'b1, lifo_count <= DEPTH_C)
  `SQH_ASSERT_IMP(a_heap_bound, clk, rst, 1'b1, heap_count <= DEPTH_C)
  `SQH_ASSERT_NXT(a_dead_stays, clk, rst, !alive[0] && !(cmd.load && start_new), !alive[0])
endmodule
`default_nettype wire

>>> sv/stack_queue_heap_trace_checker.sv
// ----------------------------------------------------------------------------
// stack_queue_heap_trace_checker
// Classifies a push/pop trace as stack, queue or priority queue behaviour.
// ----------------------------------------------------------------------------
// Channel | Signals                              | Direction
// in      | in_valid/in_ready, start_new,        | to block
//         | req_type, value                      |
// out     | out_valid/out_ready, stack_ok,       | from block
//         | queue_ok, heap_ok, verdict, overflow |
//
// A request without heap work passes through load, linear and done. A heap
// push adds a parent read and compare per level climbed, a heap pop adds a
// last-element read and a left read, right read and compare per level, and
// both end in a hole write, through the single heap memory port.
// Reset clears counts, pointers and flags only; stores need no clearing pass.
// A result held by a stalled consumer stops the next result being written.
`default_nettype none
module stack_queue_heap_trace_checker
  import sqh_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        start_new,
  input  wire logic        req_type,
  input  wire logic [15:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             stack_ok,
  output logic             queue_ok,
  output logic             heap_ok,
  output logic [2:0]       verdict,
  output logic             overflow
);
  sqh_cmd_t    cmd;
  sqh_status_t status;

  // The controller sequences the request; the datapath holds the stores, pointers and flags.
  sqh_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .status
  );

  sqh_datapath #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk, .rst, .start_new, .req_type, .value, .cmd, .status,
    .stack_ok, .queue_ok, .heap_ok, .verdict, .overflow
  );
endmodule
`default_nettype wire
